@@ src/ohs_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered hash set package
// Shared types and codes for the ordered hash set block.
// ----------------------------------------------------------------------------
package ohs_pkg;

	// Request codes.
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_GET    = 2'd2;
	localparam logic [1:0] REQ_SIZE   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_PRESENT = 3'd1;
	localparam logic [2:0] ST_REMOVED = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_ITEM    = 3'd4;
	localparam logic [2:0] ST_BADPOS  = 3'd5;
	localparam logic [2:0] ST_FULL    = 3'd6;
	localparam logic [2:0] ST_NULL    = 3'd7;

	// Slot state codes.
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_LIVE  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	// Configuration register indexes.
	localparam int unsigned REG_FILL  = 0;
	localparam int unsigned REG_REUSE = 1;

	// Golden-ratio multiplier for the home slot.
	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	localparam int unsigned CFG_W = 6;

endpackage

@@ src/ohs_if.sv @@
// ----------------------------------------------------------------------------
// Ordered hash set channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ohs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] key;
	logic [5:0]  list_position;
	modport source (output valid, req_type, key, list_position, input ready);
	modport sink (input valid, req_type, key, list_position, output ready);
endinterface

interface ohs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] item_out;
	logic [6:0]  live_count;
	modport source (output valid, status, item_out, live_count, input ready);
	modport sink (input valid, status, item_out, live_count, output ready);
endinterface

@@ src/ohs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ohs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/ohs_hash.sv @@
// ----------------------------------------------------------------------------
// Home slot hash
// Registered multiply of the key by the golden-ratio constant, low bits kept.
// ----------------------------------------------------------------------------
module ohs_hash #(
	parameter int KEY_BITS = 32,
	parameter int SLOTS    = 64
) (
	input  logic                     clk,
	input  logic [KEY_BITS-1:0]      key,
	output logic [$clog2(SLOTS)-1:0] home_q
);

	localparam int AW = $clog2(SLOTS);

	logic [AW-1:0] prod;

	// Only the low address bits of the product matter, so a narrow product suffices.
	assign prod = AW'(key[AW-1:0] * ohs_pkg::HASH_MULT[AW-1:0]);

	always_ff @(posedge clk) begin
		home_q <= prod;
	end

endmodule

@@ src/ordered_hash_set_linear_probe.sv @@
// ----------------------------------------------------------------------------
// Ordered hash set with linear probing
// Open-addressed set of nonzero keys with tombstones and an insertion-order
// list, driven by a small sequencer around one probe/compare unit.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (add, remove, get by position, size) and one
// result word per request leaves on rsp. Two registers, fill_limit and
// reuse_limit, are written over the APB port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// The block holds one request at a time: req.ready is low from acceptance
// until the result word has been taken. Time is set by the probe walk, each
// slot a registered RAM read, then a compare. Size and null-key requests are
// answered directly; get reads the order list; add walks the probe path,
// first compacting the table (clear it, re-place every live key) when the
// fill limit is reached and the reuse limit allows; remove walks the probe
// path, then rewrites the order list entry by entry. After reset the slot
// state table is swept clear, one slot at a time, and no request is taken
// meanwhile. If the receiver stalls, the result word is held and no new
// request is taken until it is accepted.
// ----------------------------------------------------------------------------
module ordered_hash_set_linear_probe #(
	parameter int SLOTS    = 64,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ohs_req_if.sink     req,
	ohs_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = AW + 1;

	typedef enum logic [13:0] {
		S_CLEAR   = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_HASH    = 14'b00000000000100,
		S_RD      = 14'b00000000001000,
		S_CMP     = 14'b00000000010000,
		S_DECIDE  = 14'b00000000100000,
		S_RMRD    = 14'b00000001000000,
		S_RMCMP   = 14'b00000010000000,
		S_GETRD   = 14'b00000100000000,
		S_GETWT   = 14'b00001000000000,
		S_CPCLR   = 14'b00010000000000,
		S_CPRD    = 14'b00100000000000,
		S_CPWT    = 14'b01000000000000,
		S_OUT     = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [ohs_pkg::CFG_W-1:0] fill_q, reuse_q;
	logic [1:0]          type_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AW-1:0]       pos_q;
	logic [CW-1:0]       live_q, used_q;
	logic [AW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic                tomb_v_q, blocked_q, compact_q, found_q, have_q;
	logic [AW-1:0]       tomb_q, at_q;
	logic [CW-1:0]       cj_q, rj_q, rw_q;
	logic [2:0]          status_q;
	logic [31:0]         item_q;

	// Original request key kept aside while compaction probes list keys.
	logic [KEY_BITS-1:0] ckey_q;

	// Whether the chosen free slot was empty (not a tombstone).
	logic srd_at_empty_q;

	// Config port.
	logic wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 6'd48;
			reuse_q <= 6'd38;
		end else if (wr_en) begin
			if (paddr[2] == 1'(ohs_pkg::REG_FILL)) fill_q <= pwdata[5:0];
			else reuse_q <= pwdata[5:0];
		end
	end
	always_comb begin
		prdata = (paddr[2] == 1'(ohs_pkg::REG_FILL)) ? {26'd0, fill_q} : {26'd0, reuse_q};
	end

	// Stores: key and status per slot, plus the order list.
	logic            kwe, swe, owe;
	logic [AW-1:0]   kwa, swa, owa, kra, ora;
	logic [KEY_BITS-1:0] kwd, owd, krd, ord;
	logic [1:0]      swd, srd;

	ohs_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
		.clk(clk), .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(krd));
	ohs_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_stat (
		.clk(clk), .we(swe), .waddr(swa), .wdata(swd), .raddr(kra), .rdata(srd));
	ohs_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_ord (
		.clk(clk), .we(owe), .waddr(owa), .wdata(owd), .raddr(ora), .rdata(ord));

	// Hash unit, shared by requests and compaction.
	logic [KEY_BITS-1:0] hkey;
	logic [AW-1:0]       home;
	ohs_hash #(.KEY_BITS(KEY_BITS), .SLOTS(SLOTS)) u_hash (
		.clk(clk), .key(hkey), .home_q(home));

	// The hash input is the key whose probe starts in the following cycle.
	logic [KEY_BITS-1:0] in_key;
	assign in_key = KEY_BITS'(req.key);
	assign hkey   = (state_q == S_CPWT) ? ord
		: (state_q == S_IDLE) ? in_key
		: (state_q == S_DECIDE && compact_q) ? ckey_q : key_q;
	assign kra = idx_q;
	assign ora = (state_q == S_GETRD) ? pos_q : rj_q[AW-1:0];

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = (state_q == S_OUT);
	assign rsp.status     = status_q;
	assign rsp.item_out   = item_q;
	assign rsp.live_count = 7'(live_q);

	// Probe step results.
	logic hit, stop, last;
	assign hit  = (srd == ohs_pkg::SLOT_LIVE) && (krd == key_q);
	assign stop = (srd == ohs_pkg::SLOT_EMPTY);
	assign last = (cnt_q == CW'(SLOTS - 1));

	logic [AW-1:0] free_at;
	assign free_at = tomb_v_q ? tomb_q : idx_q;

	// Write port selection.
	always_comb begin
		kwe = 1'b0; kwa = at_q; kwd = key_q;
		swe = 1'b0; swa = at_q; swd = ohs_pkg::SLOT_LIVE;
		owe = 1'b0; owa = live_q[AW-1:0]; owd = key_q;
		case (state_q)
			S_CLEAR, S_CPCLR: begin
				swe = 1'b1; swa = idx_q; swd = ohs_pkg::SLOT_EMPTY;
			end
			S_DECIDE: begin
				if (type_q == ohs_pkg::REQ_REMOVE) begin
					swe = found_q; swd = ohs_pkg::SLOT_TOMB;
				end else if (!found_q && have_q && !blocked_q
						&& live_q < CW'(SLOTS)) begin
					kwe = 1'b1; swe = 1'b1; owe = !compact_q;
				end
			end
			S_RMCMP: begin
				owe = (ord != key_q); owa = rw_q[AW-1:0]; owd = ord;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
			live_q  <= '0;
			used_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == AW'(SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						type_q    <= req.req_type;
						key_q     <= in_key;
						pos_q     <= req.list_position[AW-1:0];
						item_q    <= '0;
						compact_q <= 1'b0;
						blocked_q <= 1'b0;
						case (req.req_type)
							ohs_pkg::REQ_ADD, ohs_pkg::REQ_REMOVE: begin
								if (in_key == '0) begin
									status_q <= ohs_pkg::ST_NULL;
									state_q  <= S_OUT;
								end else if (req.req_type == ohs_pkg::REQ_ADD
										&& (used_q + 1'b1) >= CW'(fill_q)) begin
									if ((live_q + 1'b1) <= CW'(reuse_q)) begin
										idx_q   <= '0;
										state_q <= S_CPCLR;
									end else begin
										blocked_q <= 1'b1;
										state_q   <= S_HASH;
									end
								end else begin
									state_q <= S_HASH;
								end
							end
							ohs_pkg::REQ_GET: state_q <= S_GETRD;
							default: begin
								status_q <= ohs_pkg::ST_ITEM;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_HASH: begin
					idx_q    <= home;
					cnt_q    <= '0;
					tomb_v_q <= 1'b0;
					state_q  <= S_RD;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					found_q <= hit;
					if (hit) begin
						have_q <= 1'b1; at_q <= idx_q; state_q <= S_DECIDE;
					end else if (stop) begin
						have_q <= 1'b1; at_q <= free_at; state_q <= S_DECIDE;
					end else begin
						if (srd == ohs_pkg::SLOT_TOMB && !tomb_v_q) begin
							tomb_v_q <= 1'b1; tomb_q <= idx_q;
						end
						if (last) begin
							// Whole table walked: fall back on the first tombstone.
							at_q    <= free_at;
							have_q  <= tomb_v_q || (srd == ohs_pkg::SLOT_TOMB);
							state_q <= S_DECIDE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_DECIDE: begin
					if (compact_q) begin
						// Re-placement of one order-list key during compaction.
						if (!found_q && have_q) used_q <= used_q + 1'b1;
						cj_q  <= cj_q + 1'b1;
						key_q <= ckey_q;
						if (cj_q + 1'b1 < live_q && cj_q + 1'b1 < CW'(SLOTS)) begin
							rj_q    <= cj_q + 1'b1;
							state_q <= S_CPRD;
						end else begin
							compact_q <= 1'b0;
							state_q   <= S_HASH;
						end
					end else if (type_q == ohs_pkg::REQ_REMOVE) begin
						if (found_q) begin
							rj_q <= '0; rw_q <= '0;
							status_q <= ohs_pkg::ST_REMOVED;
							state_q  <= (live_q == '0) ? S_OUT : S_RMRD;
						end else begin
							status_q <= ohs_pkg::ST_ABSENT;
							state_q  <= S_OUT;
						end
					end else begin
						if (found_q) status_q <= ohs_pkg::ST_PRESENT;
						else if (blocked_q || !have_q || live_q >= CW'(SLOTS))
							status_q <= ohs_pkg::ST_FULL;
						else begin
							status_q <= ohs_pkg::ST_ADDED;
							live_q   <= live_q + 1'b1;
							if (srd_at_empty_q) used_q <= used_q + 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_RMRD: state_q <= S_RMCMP;
				S_RMCMP: begin
					if (ord != key_q) rw_q <= rw_q + 1'b1;
					rj_q <= rj_q + 1'b1;
					if (rj_q + 1'b1 < live_q && rj_q + 1'b1 < CW'(SLOTS))
						state_q <= S_RMRD;
					else begin
						live_q  <= rw_q + ((ord != key_q) ? 1'b1 : 1'b0);
						state_q <= S_OUT;
					end
				end
				S_GETRD: state_q <= S_GETWT;
				S_GETWT: begin
					if (CW'(pos_q) < live_q) begin
						status_q <= ohs_pkg::ST_ITEM;
						item_q   <= 32'(ord);
					end else begin
						status_q <= ohs_pkg::ST_BADPOS;
					end
					state_q <= S_OUT;
				end
				S_CPCLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == AW'(SLOTS - 1)) begin
						used_q <= '0;
						cj_q   <= '0;
						rj_q   <= '0;
						if (live_q == '0) state_q <= S_HASH;
						else begin
							compact_q <= 1'b1;
							state_q   <= S_CPRD;
						end
					end
				end
				S_CPRD: state_q <= S_CPWT;
				S_CPWT: begin
					// The hash of the order-list word is taken here; swap keys for probing.
					ckey_q  <= key_q;
					key_q   <= ord;
					state_q <= S_HASH;
				end
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Note whether the free slot picked by the probe was empty.
	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			srd_at_empty_q <= stop && !tomb_v_q;
		end
	end

endmodule

@@ src/ohs_checker.sv @@
// ----------------------------------------------------------------------------
// Ordered hash set port checker
// Watches the top level's ports for result and occupancy rules.
// ----------------------------------------------------------------------------
module ohs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [31:0] item_out,
	input logic [6:0]  live_count
);

	// Never ready to take a request while a result word is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("ready while result pending");

	// Only a get with a valid position carries a nonzero item.
	a_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ohs_pkg::ST_ITEM |-> item_out == 32'd0)
		else $error("item on non-item status");

	// The live count never exceeds the table size.
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> live_count <= 7'd64) else $error("count out of range");

	// A stalled result holds its status.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("result dropped under stall");

endmodule

bind ordered_hash_set_linear_probe ohs_checker u_ohs_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.status(rsp.status), .item_out(rsp.item_out), .live_count(rsp.live_count)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered hash set testbench
// Drives add, remove, get and size requests through the valid/ready channels,
// steps the two limit registers over the APB port between phases, and checks
// every result word against a cycle-free model of the set kept in a small
// scoreboard class.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [2:0]  status;
	logic [31:0] item_out;
	logic [6:0]  live_count;
} set_answer_t;

class set_scoreboard;
	logic [31:0] slot_key[64];
	logic [1:0]  slot_state[64];
	logic [31:0] order[64];
	int          live;
	int          used;
	logic [5:0]  fill_lim;
	logic [5:0]  reuse_lim;
	set_answer_t answers[$];
	int          errors;

	function new();
		foreach (slot_state[i]) slot_state[i] = ohs_pkg::SLOT_EMPTY;
		live = 0;
		used = 0;
		fill_lim = 6'd48;
		reuse_lim = 6'd38;
		errors = 0;
	endfunction

	function void set_limit(int unsigned idx, logic [31:0] value);
		if (idx == ohs_pkg::REG_FILL) fill_lim = value[5:0];
		else if (idx == ohs_pkg::REG_REUSE) reuse_lim = value[5:0];
	endfunction

	// Walks the probe path; returns 1 if the key is live, with its slot in at.
	// Otherwise at is the first tombstone or empty slot, or -1.
	function bit locate(logic [31:0] k, output int at);
		logic [31:0] prod;
		int i;
		int tomb;
		prod = k * ohs_pkg::HASH_MULT;
		i = prod[5:0];
		tomb = -1;
		for (int n = 0; n < 64; n++) begin
			if (slot_state[i] == ohs_pkg::SLOT_LIVE) begin
				if (slot_key[i] == k) begin
					at = i;
					return 1;
				end
			end else if (slot_state[i] == ohs_pkg::SLOT_TOMB) begin
				if (tomb < 0) tomb = i;
			end else begin
				at = (tomb >= 0) ? tomb : i;
				return 0;
			end
			i = (i + 1) % 64;
		end
		at = tomb;
		return 0;
	endfunction

	// Rebuilds the table from the insertion-order list.
	function void rebuild();
		int at;
		foreach (slot_state[i]) slot_state[i] = ohs_pkg::SLOT_EMPTY;
		used = 0;
		for (int j = 0; j < live; j++) begin
			if (!locate(order[j], at) && at >= 0) begin
				slot_key[at] = order[j];
				slot_state[at] = ohs_pkg::SLOT_LIVE;
				used++;
			end
		end
	endfunction

	// Notes an accepted request and works out the answer it must produce.
	function void note_request(logic [1:0] kind, logic [31:0] k, logic [5:0] pos);
		set_answer_t a;
		int at;
		int w;
		bit blocked;
		a.item_out = '0;
		case (kind)
			ohs_pkg::REQ_ADD: begin
				if (k == 0) a.status = ohs_pkg::ST_NULL;
				else begin
					blocked = 0;
					if (used + 1 >= fill_lim) begin
						if (live + 1 <= reuse_lim) rebuild();
						else blocked = 1;
					end
					if (locate(k, at)) a.status = ohs_pkg::ST_PRESENT;
					else if (blocked || at < 0 || live >= 64) a.status = ohs_pkg::ST_FULL;
					else begin
						if (slot_state[at] == ohs_pkg::SLOT_EMPTY) used++;
						slot_key[at] = k;
						slot_state[at] = ohs_pkg::SLOT_LIVE;
						order[live] = k;
						live++;
						a.status = ohs_pkg::ST_ADDED;
					end
				end
			end
			ohs_pkg::REQ_REMOVE: begin
				if (k == 0) a.status = ohs_pkg::ST_NULL;
				else if (locate(k, at)) begin
					slot_state[at] = ohs_pkg::SLOT_TOMB;
					w = 0;
					for (int j = 0; j < live; j++) begin
						if (order[j] != k) begin
							order[w] = order[j];
							w = w + 1;
						end
					end
					live = w;
					a.status = ohs_pkg::ST_REMOVED;
				end else a.status = ohs_pkg::ST_ABSENT;
			end
			ohs_pkg::REQ_GET: begin
				if (pos < live) begin
					a.status = ohs_pkg::ST_ITEM;
					a.item_out = order[pos];
				end else a.status = ohs_pkg::ST_BADPOS;
			end
			default: a.status = ohs_pkg::ST_ITEM;
		endcase
		a.live_count = live[6:0];
		answers.push_back(a);
	endfunction

	// Compares one result word with the oldest waiting answer.
	function void check_result(logic [2:0] st, logic [31:0] item, logic [6:0] cnt);
		set_answer_t a;
		if (answers.size() == 0) begin
			$error("result word with no request waiting");
			errors++;
			return;
		end
		a = answers.pop_front();
		if (st !== a.status) begin
			$error("status: expected %0d, actual %0d", a.status, st);
			errors++;
		end
		if (item !== a.item_out) begin
			$error("item_out: expected %h, actual %h", a.item_out, item);
			errors++;
		end
		if (cnt !== a.live_count) begin
			$error("live_count: expected %0d, actual %0d", a.live_count, cnt);
			errors++;
		end
	endfunction
endclass

module tb;
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	bit          calm;
	logic [31:0] key_pool[48];
	set_scoreboard sb;

	ohs_req_if rq ();
	ohs_rsp_if rs ();

	ordered_hash_set_linear_probe dut (
		.clk(clk), .arst_n(arst_n), .req(rq), .rsp(rs),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#200ms;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver side: stalls now and then unless in a calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) rs.ready <= 1'b0;
		else rs.ready <= calm || ($urandom_range(99) >= 10);
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && rs.valid && rs.ready)
			sb.check_result(rs.status, rs.item_out, rs.live_count);
	end

	// One APB write: setup cycle, then access cycle.
	task automatic apb_write(int unsigned idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_limit(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Presents one request word and holds it until it is taken.
	task automatic send(logic [1:0] kind, logic [31:0] k, logic [5:0] pos);
		if (!calm && $urandom_range(99) < 10) begin
			rq.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rq.valid <= 1'b1;
		rq.req_type <= kind;
		rq.key <= k;
		rq.list_position <= pos;
		do @(posedge clk); while (!rq.ready);
		sb.note_request(kind, k, pos);
	endtask

	// Waits until every answer is in, with the valid line low.
	task automatic drain();
		@(posedge clk);
		rq.valid <= 1'b0;
		while (sb.answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Fresh key pool: half random, half sharing a home slot.
	task automatic fill_pool();
		logic [31:0] base;
		base = $urandom;
		foreach (key_pool[i])
			key_pool[i] = (i < 24) ? $urandom : base + 32'(64 * i);
	endtask

	// Random traffic, mostly adds and removes on the pool.
	task automatic random_run(int n);
		int r;
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 2) && (i < n / 2 + n / 5);
			r = $urandom_range(99);
			k = ($urandom_range(19) == 0) ? $urandom : key_pool[$urandom_range(47)];
			if (r < 45) send(ohs_pkg::REQ_ADD, k, 6'($urandom));
			else if (r < 70) send(ohs_pkg::REQ_REMOVE, k, 6'($urandom));
			else if (r < 90) send(ohs_pkg::REQ_GET, $urandom, $urandom_range(63));
			else if (r < 95) send(ohs_pkg::REQ_SIZE, $urandom, 6'($urandom));
			else send(2'($urandom_range(1)), 32'd0, 6'($urandom));
		end
		calm = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rq.valid = 1'b0;
		rq.req_type = ohs_pkg::REQ_SIZE;
		rq.key = '0;
		rq.list_position = '0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corner cases at the reset limits.
		send(ohs_pkg::REQ_SIZE, 32'd0, 6'd0);
		send(ohs_pkg::REQ_GET, 32'd0, 6'd0);
		send(ohs_pkg::REQ_ADD, 32'd0, 6'd0);
		send(ohs_pkg::REQ_REMOVE, 32'd0, 6'd63);
		send(ohs_pkg::REQ_ADD, 32'd1, 6'd0);
		send(ohs_pkg::REQ_ADD, 32'hFFFF_FFFF, 6'd0);
		send(ohs_pkg::REQ_ADD, 32'h8000_0000, 6'd0);
		send(ohs_pkg::REQ_ADD, 32'd1, 6'd0);
		send(ohs_pkg::REQ_ADD, 32'd65, 6'd0);
		send(ohs_pkg::REQ_ADD, 32'd129, 6'd0);
		send(ohs_pkg::REQ_GET, 32'd0, 6'd0);
		send(ohs_pkg::REQ_GET, 32'd0, 6'd4);
		send(ohs_pkg::REQ_GET, 32'd0, 6'd5);
		send(ohs_pkg::REQ_GET, 32'd0, 6'd63);
		send(ohs_pkg::REQ_REMOVE, 32'd2, 6'd0);
		send(ohs_pkg::REQ_REMOVE, 32'd65, 6'd0);
		send(ohs_pkg::REQ_ADD, 32'd193, 6'd0);
		send(ohs_pkg::REQ_REMOVE, 32'd1, 6'd0);
		send(ohs_pkg::REQ_GET, 32'd0, 6'd0);
		send(ohs_pkg::REQ_SIZE, 32'hFFFF_FFFF, 6'h3F);
		drain();

		fill_pool();
		random_run(200);
		drain();

		// Settings sweep, extremes included.
		apb_write(ohs_pkg::REG_FILL, 32'd63);
		apb_write(ohs_pkg::REG_REUSE, 32'd63);
		fill_pool();
		random_run(300);
		drain();
		apb_write(ohs_pkg::REG_FILL, 32'd1);
		apb_write(ohs_pkg::REG_REUSE, 32'd1);
		random_run(150);
		drain();
		apb_write(ohs_pkg::REG_FILL, 32'd20);
		apb_write(ohs_pkg::REG_REUSE, 32'd10);
		fill_pool();
		random_run(250);
		drain();
		apb_write(ohs_pkg::REG_FILL, 32'd0);
		apb_write(ohs_pkg::REG_REUSE, 32'd8);
		random_run(150);
		drain();
		apb_write(ohs_pkg::REG_FILL, 32'd63);
		apb_write(ohs_pkg::REG_REUSE, 32'd1);
		fill_pool();
		random_run(250);
		drain();
		for (int p = 0; p < 2; p++) begin
			apb_write(ohs_pkg::REG_FILL, $urandom_range(12, 63));
			apb_write(ohs_pkg::REG_REUSE, $urandom_range(1, 63));
			fill_pool();
			random_run(225);
			drain();
		end

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.answers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
